// ===== rtl/rpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants of the regex pattern tokenizer
// Holds the parse flag layout, the action and error codes and the pattern
// bytes that the decoder recognizes.
// ----------------------------------------------------------------------------
package rpt_pkg;

	// Parse flags, most significant member first so that quant is bit 0.
	typedef struct packed {
		logic multi;   // inside a bracket class
		logic esc;     // escape pending
		logic qtfr;    // latest token already carries a quantifier
		logic quant;   // latest token can take a quantifier
	} flags_t;

	// Token-building actions.
	typedef enum logic [3:0] {
		ACT_NONE     = 4'd0,
		ACT_LITERAL  = 4'd1,
		ACT_ANY      = 4'd2,
		ACT_OPEN_CLS = 4'd3,
		ACT_ADD_CLS  = 4'd4,
		ACT_PLUS     = 4'd5,
		ACT_STAR     = 4'd6,
		ACT_OPTIONAL = 4'd7,
		ACT_LAZY     = 4'd8
	} action_t;

	// Error codes.
	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_UNBALANCED = 3'd1,
		ERR_BAD_ESC    = 3'd2,
		ERR_DUP_QUANT  = 3'd3,
		ERR_TRAIL_ESC  = 3'd4,
		ERR_NO_TARGET  = 3'd5
	} err_t;

	// Result of one pattern byte.
	typedef struct packed {
		action_t    action;
		logic [7:0] token_char;
		err_t       error_code;
		logic       pattern_done;
	} result_t;

	// Pattern bytes with a special meaning.
	localparam logic [7:0] CH_LBRACK    = 8'h5b;
	localparam logic [7:0] CH_RBRACK    = 8'h5d;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACE    = 8'h7b;
	localparam logic [7:0] CH_RBRACE    = 8'h7d;
	localparam logic [7:0] CH_PLUS      = 8'h2b;
	localparam logic [7:0] CH_STAR      = 8'h2a;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT       = 8'h2e;
	localparam logic [7:0] CH_QUESTION  = 8'h3f;

endpackage

// ===== rtl/rpt_if.sv =====
// ----------------------------------------------------------------------------
// rpt_in_if / rpt_out_if: valid/ready channels of the tokenizer
// A transaction completes at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface rpt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pattern_char;
	logic       is_last;

	modport source (output valid, output pattern_char, output is_last, input ready);
	modport sink (input valid, input pattern_char, input is_last, output ready);
endinterface

interface rpt_out_if;
	logic            valid;
	logic            ready;
	rpt_pkg::action_t action;
	logic [7:0]      token_char;
	rpt_pkg::err_t   error_code;
	logic            pattern_done;

	modport source (output valid, output action, output token_char, output error_code,
		output pattern_done, input ready);
	modport sink (input valid, input action, input token_char, input error_code,
		input pattern_done, output ready);
endinterface

// ===== rtl/rpt_decode.sv =====
// ----------------------------------------------------------------------------
// rpt_decode: per-byte decoder of the tokenizer
// Maps one pattern byte and the current parse state to a result and to the
// next parse state. Purely combinational.
// ----------------------------------------------------------------------------
module rpt_decode (
	input  logic             [7:0] pattern_char,
	input  logic                   is_last,
	input  rpt_pkg::flags_t        flags,
	input  logic                   err_latched,
	output rpt_pkg::result_t       result,
	output rpt_pkg::flags_t        flags_next,
	output logic                   err_latched_next
);
	import rpt_pkg::*;

	action_t    act;
	logic [7:0] tch;
	err_t       err;
	flags_t     nf;
	action_t    q_act;

	// Quantifier action selected by the byte.
	always_comb begin
		if (pattern_char == CH_PLUS) begin
			q_act = ACT_PLUS;
		end else if (pattern_char == CH_STAR) begin
			q_act = ACT_STAR;
		end else begin
			q_act = ACT_OPTIONAL;
		end
	end

	// Byte classification and flag update.
	always_comb begin
		act = ACT_NONE;
		tch = 8'h00;
		err = ERR_OK;
		nf  = flags;
		unique case (pattern_char)
			CH_LBRACK: begin
				if (flags.esc) begin
					act = flags.multi ? ACT_ADD_CLS : ACT_LITERAL;
					tch = pattern_char;
				end else if (flags.multi) begin
					err = ERR_UNBALANCED;
				end else begin
					act = ACT_OPEN_CLS;
				end
			end
			CH_RBRACK: begin
				if (flags.esc) begin
					act = flags.multi ? ACT_ADD_CLS : ACT_LITERAL;
					tch = pattern_char;
				end else if (!flags.multi) begin
					err = ERR_UNBALANCED;
				end
			end
			CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: begin
				act = ACT_NONE;
			end
			CH_PLUS, CH_STAR: begin
				if (flags.esc) begin
					if (flags.multi) begin
						err = ERR_BAD_ESC;
					end else begin
						act = ACT_LITERAL;
						tch = pattern_char;
					end
				end else if (flags.multi) begin
					act = ACT_ADD_CLS;
					tch = pattern_char;
				end else if (flags.qtfr) begin
					err = ERR_DUP_QUANT;
				end else if (!flags.quant) begin
					err = ERR_NO_TARGET;
				end else begin
					act = q_act;
				end
			end
			CH_BACKSLASH: begin
				if (flags.esc) begin
					act = flags.multi ? ACT_ADD_CLS : ACT_LITERAL;
					tch = pattern_char;
				end
			end
			CH_DOT: begin
				if (flags.multi || flags.esc) begin
					act = flags.multi ? ACT_ADD_CLS : ACT_LITERAL;
					tch = pattern_char;
				end else begin
					act = ACT_ANY;
				end
			end
			CH_QUESTION: begin
				if (flags.esc) begin
					act = flags.multi ? ACT_ADD_CLS : ACT_LITERAL;
					tch = pattern_char;
				end else if (flags.qtfr) begin
					act = ACT_LAZY;
				end else if (flags.multi) begin
					act = ACT_ADD_CLS;
					tch = pattern_char;
				end else if (!flags.quant) begin
					err = ERR_NO_TARGET;
				end else begin
					act = q_act;
				end
			end
			default: begin
				if (flags.multi && flags.esc) begin
					err = ERR_BAD_ESC;
				end else begin
					act = flags.multi ? ACT_ADD_CLS : ACT_LITERAL;
					tch = pattern_char;
				end
			end
		endcase

		// Flag effects of the chosen action.
		if (err == ERR_OK) begin
			unique case (act)
				ACT_LITERAL: begin
					nf.esc   = 1'b0;
					nf.qtfr  = 1'b0;
					nf.quant = 1'b1;
				end
				ACT_ADD_CLS: begin
					nf.esc = 1'b0;
				end
				ACT_ANY: begin
					nf.qtfr  = 1'b0;
					nf.quant = 1'b1;
				end
				ACT_OPEN_CLS: begin
					nf = '{multi: 1'b1, esc: 1'b0, qtfr: 1'b0, quant: 1'b0};
				end
				ACT_PLUS, ACT_STAR, ACT_OPTIONAL: begin
					nf.quant = 1'b0;
					nf.qtfr  = 1'b1;
				end
				ACT_LAZY: begin
					nf = flags;
				end
				ACT_NONE: begin
					if (pattern_char == CH_RBRACK) begin
						nf = '{multi: 1'b0, esc: 1'b0, qtfr: 1'b0, quant: 1'b1};
					end else if (pattern_char == CH_BACKSLASH) begin
						nf.esc = 1'b1;
						if (!flags.multi) begin
							nf.quant = 1'b0;
						end
					end
				end
				default: begin
					nf = flags;
				end
			endcase
		end
	end

	// Error latch, end-of-pattern check and final result.
	always_comb begin
		result.action       = act;
		result.token_char   = tch;
		result.error_code   = err;
		result.pattern_done = is_last;
		flags_next          = nf;
		err_latched_next    = err_latched;
		if (err_latched) begin
			result.action     = ACT_NONE;
			result.token_char = 8'h00;
			result.error_code = ERR_OK;
			flags_next        = flags;
		end else if (err != ERR_OK) begin
			result.action     = ACT_NONE;
			result.token_char = 8'h00;
			err_latched_next  = 1'b1;
		end else if (is_last) begin
			if (nf.esc) begin
				result.error_code = ERR_TRAIL_ESC;
			end else if (nf.multi) begin
				result.error_code = ERR_UNBALANCED;
			end
		end
		if (is_last) begin
			flags_next       = '0;
			err_latched_next = 1'b0;
		end
	end

endmodule

// ===== rtl/regex_pattern_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// regex_pattern_tokenizer_unit: regex pattern tokenizer
// Takes one pattern byte per transaction and returns one token-building
// action per byte, with error reporting and an end-of-pattern check.
// ----------------------------------------------------------------------------
// The tokenizer accepts one pattern byte in every clock cycle while its
// output register is free or being drained, and returns exactly one result
// per byte, in the cycle after the byte is taken. The parse flags and the
// error latch update at the input transaction, and the result goes into an
// output register that holds while the output is stalled. Throughput is one
// byte per cycle without stalls, set by the flag update loop through the decoder.
module regex_pattern_tokenizer_unit (
	input  logic      clk,
	input  logic      arst_n,
	rpt_in_if.sink    in_ch,
	rpt_out_if.source out_ch
);
	import rpt_pkg::*;

	flags_t  flags_q;
	logic    err_latched_q;
	flags_t  flags_d;
	logic    err_latched_d;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;
	logic    in_fire;

	// The input is taken whenever the output register is free or draining.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	rpt_decode u_decode (
		.pattern_char     (in_ch.pattern_char),
		.is_last          (in_ch.is_last),
		.flags            (flags_q),
		.err_latched      (err_latched_q),
		.result           (res_d),
		.flags_next       (flags_d),
		.err_latched_next (err_latched_d)
	);

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '0;
			err_latched_q <= 1'b0;
		end else if (in_fire) begin
			flags_q       <= flags_d;
			err_latched_q <= err_latched_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.action       = res_q.action;
	assign out_ch.token_char   = res_q.token_char;
	assign out_ch.error_code   = res_q.error_code;
	assign out_ch.pattern_done = res_q.pattern_done;

`ifndef SYNTHESIS
	// Every accepted byte leaves a result in the output register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("no result after accepted byte");

	// The last byte returns the parse state to its reset value.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_ch.is_last |=> (flags_q == '0) && !err_latched_q)
		else $error("state not cleared after last byte");

	// A latched error holds until the end of the pattern.
	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && err_latched_q && !in_ch.is_last |=> err_latched_q)
		else $error("error latch dropped inside a pattern");

	// A byte error carries no action unless it comes from the end check.
	a_err_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.error_code != ERR_OK) && !res_q.pattern_done
		|-> res_q.action == ACT_NONE)
		else $error("action reported with a byte error");
`endif

endmodule
